/* design/mfek_pkg.sv */
package mfek_pkg;

   localparam int FLOW_BITS = 20;
   localparam logic [FLOW_BITS-1:0] BOTTLENECK_START = 20'd1000000;

   localparam logic OP_SET_EDGE = 1'b0;
   localparam logic OP_COMPUTE  = 1'b1;

   localparam logic [1:0] CSR_SOURCE = 2'd0;
   localparam logic [1:0] CSR_SINK   = 2'd1;
   localparam logic [1:0] CSR_COUNT  = 2'd2;

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_COPY,
      ENG_SEARCH,
      ENG_SCAN_RD,
      ENG_SCAN_EV,
      ENG_NECK_RD,
      ENG_NECK_EV,
      ENG_UPD_RDF,
      ENG_UPD_RDR,
      ENG_UPD_WRR,
      ENG_DONE
   } eng_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_stat_type;

endpackage

/* design/mfek_engine.sv */
module mfek_engine #(
   parameter int MAX_VERTICES = 16,
   parameter int CAP_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_start,
   input  logic cmd_empty,
   input  logic [$clog2(MAX_VERTICES)-1:0] cmd_src,
   input  logic [$clog2(MAX_VERTICES)-1:0] cmd_dst,
   input  logic [$clog2(MAX_VERTICES):0] cmd_nv,
   output logic [2*$clog2(MAX_VERTICES)-1:0] cap_raddr,
   input  logic [CAP_BITS-1:0] cap_rdata,
   output mfek_pkg::eng_stat_type stat,
   output logic [mfek_pkg::FLOW_BITS-1:0] flow
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int AW = 2 * VW;
   localparam int DEPTH = 1 << AW;
   localparam int RW = CAP_BITS + 1;
   localparam int NW = (RW > mfek_pkg::FLOW_BITS) ? RW : mfek_pkg::FLOW_BITS;

   mfek_pkg::eng_state_type state_ff, state_in;
   logic [VW-1:0] src_ff, src_in, dst_ff, dst_in, u_ff, u_in, v_ff, v_in;
   logic [VW:0] nv_ff, nv_in, head_ff, head_in, tail_ff, tail_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [VW-1:0] parent_ff [MAX_VERTICES];
   logic [VW-1:0] parent_in [MAX_VERTICES];
   logic [VW-1:0] queue_ff [MAX_VERTICES];
   logic [VW-1:0] queue_in [MAX_VERTICES];
   logic [NW-1:0] neck_ff, neck_in;
   logic [mfek_pkg::FLOW_BITS-1:0] flow_ff, flow_in;
   logic [AW:0] copy_ff, copy_in;
   logic cw_valid_ff, cw_valid_in;
   logic [AW-1:0] cw_addr_ff, cw_addr_in;

   logic [RW-1:0] res_mem [DEPTH];
   logic [RW-1:0] res_q_ff;
   logic [AW-1:0] res_raddr, res_waddr;
   logic [RW-1:0] res_wdata;
   logic res_we;
   logic [VW-1:0] pu;
   logic cw_inside;

   assign cw_inside = ({1'b0, cw_addr_ff[AW-1:VW]} < nv_ff) && ({1'b0, cw_addr_ff[VW-1:0]} < nv_ff);
   assign pu = parent_ff[v_ff];

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[res_waddr] <= res_wdata;
      end
      res_q_ff <= res_mem[res_raddr];
   end

   always_comb begin
      state_in = state_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      nv_in = nv_ff;
      u_in = u_ff;
      v_in = v_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      visited_in = visited_ff;
      parent_in = parent_ff;
      queue_in = queue_ff;
      neck_in = neck_ff;
      flow_in = flow_ff;
      copy_in = copy_ff;
      cw_valid_in = 1'b0;
      cw_addr_in = cw_addr_ff;
      cap_raddr = copy_ff[AW-1:0];
      res_raddr = {u_ff, v_ff};
      res_we = cw_valid_ff;
      res_waddr = cw_addr_ff;
      res_wdata = cw_inside ? RW'(cap_rdata) : '0;
      stat.busy = (state_ff != mfek_pkg::ENG_IDLE);
      stat.done = 1'b0;
      case (state_ff)
         mfek_pkg::ENG_IDLE: begin
            if (cmd_start) begin
               src_in = cmd_src;
               dst_in = cmd_dst;
               nv_in = cmd_nv;
               flow_in = '0;
               copy_in = '0;
               state_in = cmd_empty ? mfek_pkg::ENG_DONE : mfek_pkg::ENG_COPY;
            end
         end
         mfek_pkg::ENG_COPY: begin
            if (copy_ff == (AW+1)'(DEPTH)) begin
               state_in = mfek_pkg::ENG_SEARCH;
            end else begin
               cw_valid_in = 1'b1;
               cw_addr_in = copy_ff[AW-1:0];
               copy_in = copy_ff + 1'b1;
            end
         end
         mfek_pkg::ENG_SEARCH: begin
            visited_in = '0;
            visited_in[src_ff] = 1'b1;
            queue_in[0] = src_ff;
            parent_in[src_ff] = src_ff;
            tail_in = (VW+1)'(1);
            head_in = (VW+1)'(1);
            u_in = src_ff;
            v_in = '0;
            state_in = mfek_pkg::ENG_SCAN_RD;
         end
         mfek_pkg::ENG_SCAN_RD: begin
            res_raddr = {u_ff, v_ff};
            state_in = mfek_pkg::ENG_SCAN_EV;
         end
         mfek_pkg::ENG_SCAN_EV: begin
            state_in = mfek_pkg::ENG_SCAN_RD;
            if (!visited_ff[v_ff] && (res_q_ff != '0)) begin
               parent_in[v_ff] = u_ff;
               visited_in[v_ff] = 1'b1;
               if (tail_ff < (VW+1)'(MAX_VERTICES)) begin
                  queue_in[tail_ff[VW-1:0]] = v_ff;
                  tail_in = tail_ff + 1'b1;
               end
            end
            if (!visited_ff[v_ff] && (res_q_ff != '0) && (v_ff == dst_ff)) begin
               v_in = dst_ff;
               neck_in = NW'(mfek_pkg::BOTTLENECK_START);
               state_in = mfek_pkg::ENG_NECK_RD;
            end else if (({1'b0, v_ff} + 1'b1) == nv_ff) begin
               if ((head_ff < tail_in) && (head_ff < (VW+1)'(MAX_VERTICES))) begin
                  u_in = queue_in[head_ff[VW-1:0]];
                  head_in = head_ff + 1'b1;
                  v_in = '0;
               end else begin
                  state_in = mfek_pkg::ENG_DONE;
               end
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         mfek_pkg::ENG_NECK_RD: begin
            u_in = pu;
            res_raddr = {pu, v_ff};
            state_in = mfek_pkg::ENG_NECK_EV;
         end
         mfek_pkg::ENG_NECK_EV: begin
            if (NW'(res_q_ff) < neck_ff) begin
               neck_in = NW'(res_q_ff);
            end
            if (u_ff == src_ff) begin
               v_in = dst_ff;
               state_in = mfek_pkg::ENG_UPD_RDF;
            end else begin
               v_in = u_ff;
               state_in = mfek_pkg::ENG_NECK_RD;
            end
         end
         mfek_pkg::ENG_UPD_RDF: begin
            u_in = pu;
            res_raddr = {pu, v_ff};
            state_in = mfek_pkg::ENG_UPD_RDR;
         end
         mfek_pkg::ENG_UPD_RDR: begin
            res_raddr = {v_ff, u_ff};
            res_we = 1'b1;
            res_waddr = {u_ff, v_ff};
            res_wdata = res_q_ff - RW'(neck_ff);
            state_in = mfek_pkg::ENG_UPD_WRR;
         end
         mfek_pkg::ENG_UPD_WRR: begin
            res_we = 1'b1;
            res_waddr = {v_ff, u_ff};
            res_wdata = res_q_ff + RW'(neck_ff);
            v_in = u_ff;
            if (u_ff == src_ff) begin
               flow_in = flow_ff + mfek_pkg::FLOW_BITS'(neck_ff);
               state_in = mfek_pkg::ENG_SEARCH;
            end else begin
               state_in = mfek_pkg::ENG_UPD_RDF;
            end
         end
         mfek_pkg::ENG_DONE: begin
            stat.done = 1'b1;
            state_in = mfek_pkg::ENG_IDLE;
         end
         default: begin
            state_in = mfek_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfek_pkg::ENG_IDLE;
         visited_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         flow_ff <= '0;
         cw_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         visited_ff <= visited_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         flow_ff <= flow_in;
         cw_valid_ff <= cw_valid_in;
      end
      src_ff <= src_in;
      dst_ff <= dst_in;
      nv_ff <= nv_in;
      u_ff <= u_in;
      v_ff <= v_in;
      parent_ff <= parent_in;
      queue_ff <= queue_in;
      neck_ff <= neck_in;
      copy_ff <= copy_in;
      cw_addr_ff <= cw_addr_in;
   end

   assign flow = flow_ff;

endmodule

/* design/max_flow_edmonds_karp.sv */
// Edge writes (operation 0) may follow every cycle while busy is low.
// A compute request (operation 1) holds busy high while the capacity matrix
// of 2^(2*clog2(MAX_VERTICES)) entries is copied into the residual memory at
// one entry a cycle. Each breadth-first search then sets up and then reads
// and examines each candidate vertex in turn through the single residual
// memory read port; each augmenting path is walked once to find its
// bottleneck and once more to update the forward and reverse residuals.
// rsp_valid then pulses for one cycle with rsp_flow_total and busy falls
// the cycle after. Source equal to sink, or either outside the vertex count,
// answers 0 without a copy or search. After reset the capacity memory is
// swept to zero, one entry a cycle (256 entries by default), with busy high.
// The receiver cannot stall: take rsp_flow_total whenever rsp_valid is high.
module max_flow_edmonds_karp #(
   parameter int MAX_VERTICES = 16,
   parameter int CAP_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_operation,
   input  logic [3:0] req_from_vertex,
   input  logic [3:0] req_to_vertex,
   input  logic [15:0] req_capacity,
   output logic rsp_valid,
   output logic [19:0] rsp_flow_total,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_data
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int AW = 2 * VW;
   localparam int DEPTH = 1 << AW;

   logic [3:0] src_ff, src_in, dst_ff, dst_in;
   logic [4:0] count_ff, count_in;
   logic [AW:0] clr_ff, clr_in;
   logic clearing, accept, edge_ok, cmd_start, cmd_empty;
   logic [VW:0] nv;
   logic [CAP_BITS-1:0] cap_mem [DEPTH];
   logic [CAP_BITS-1:0] cap_q_ff;
   logic [AW-1:0] cap_raddr;
   mfek_pkg::eng_stat_type stat;

   assign clearing = (clr_ff != (AW+1)'(DEPTH));
   assign busy = clearing || stat.busy;
   assign accept = start && !busy;
   assign edge_ok = accept && (req_operation == mfek_pkg::OP_SET_EDGE)
                    && (int'(req_from_vertex) < MAX_VERTICES)
                    && (int'(req_to_vertex) < MAX_VERTICES);
   assign cmd_start = accept && (req_operation == mfek_pkg::OP_COMPUTE);
   assign nv = (int'(count_ff) > MAX_VERTICES) ? (VW+1)'(MAX_VERTICES) : (VW+1)'(count_ff);
   assign cmd_empty = (int'(src_ff) >= int'(nv)) || (int'(dst_ff) >= int'(nv))
                      || (src_ff == dst_ff);
   assign csr_ready = 1'b1;
   assign clr_in = clearing ? clr_ff + 1'b1 : clr_ff;

   always_comb begin
      src_in = src_ff;
      dst_in = dst_ff;
      count_in = count_ff;
      if (csr_valid) begin
         case (csr_index)
            mfek_pkg::CSR_SOURCE: src_in = csr_data[3:0];
            mfek_pkg::CSR_SINK:   dst_in = csr_data[3:0];
            mfek_pkg::CSR_COUNT:  count_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= 4'd0;
         dst_ff <= 4'd1;
         count_ff <= 5'd16;
         clr_ff <= '0;
      end else begin
         src_ff <= src_in;
         dst_ff <= dst_in;
         count_ff <= count_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         cap_mem[clr_ff[AW-1:0]] <= '0;
      end else if (edge_ok) begin
         cap_mem[{VW'(req_from_vertex), VW'(req_to_vertex)}] <= CAP_BITS'(req_capacity);
      end
      cap_q_ff <= cap_mem[cap_raddr];
   end

   mfek_engine #(
      .MAX_VERTICES(MAX_VERTICES),
      .CAP_BITS(CAP_BITS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .cmd_start(cmd_start),
      .cmd_empty(cmd_empty),
      .cmd_src(VW'(src_ff)),
      .cmd_dst(VW'(dst_ff)),
      .cmd_nv(nv),
      .cap_raddr(cap_raddr),
      .cap_rdata(cap_q_ff),
      .stat(stat),
      .flow(rsp_flow_total)
   );

   assign rsp_valid = stat.done;

endmodule

/* design/mfek_checker.sv */
module mfek_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_operation,
   input logic rsp_valid
);

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");

   a_compute_holds: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == mfek_pkg::OP_COMPUTE)) |=> busy)
      else $error("compute request did not raise busy");

   a_edge_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == mfek_pkg::OP_SET_EDGE)) |=> !rsp_valid)
      else $error("edge request produced a result");

endmodule

bind max_flow_edmonds_karp mfek_checker u_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_operation(req_operation),
   .rsp_valid(rsp_valid)
);
